/* design/hte_pkg.sv */
// shared types and constants of the table-driven prefix-code encoder
package hte_pkg;

    localparam int SYMBOLS_DEF      = 128;
    localparam int MAX_CODE_LEN_DEF = 32;

    localparam int SYM_W    = 8;
    localparam int LEN_W    = 6;
    localparam int CODE_W   = 32;
    localparam int BYTE_W   = 8;
    localparam int PEND_W   = 4;
    localparam int STREAM_W = BYTE_W + CODE_W;
    localparam int CNT_W    = 3;
    localparam int MODE_W   = 2;
    localparam int IN_W     = 48;

    localparam int EOT_SYMBOL = 4;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD   = 2'd0,
        MODE_ENCODE = 2'd1,
        MODE_END    = 2'd2
    } t_mode;

endpackage

/* design/hte_table.sv */
// code table: code bits and lengths in a memory, per-entry valid bits in flops
module hte_table
    import hte_pkg::*;
#(
    parameter int SYMBOLS = SYMBOLS_DEF,
    localparam int IDX_W  = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic [IDX_W-1:0]  i_wr_addr,
    input  logic [LEN_W-1:0]  i_wr_len,
    input  logic [CODE_W-1:0] i_wr_bits,
    input  logic              i_rd_en,
    input  logic [IDX_W-1:0]  i_rd_addr,
    output logic [LEN_W-1:0]  o_rd_len,
    output logic [CODE_W-1:0] o_rd_bits
);

    logic [LEN_W+CODE_W-1:0] r_mem [SYMBOLS];
    logic [SYMBOLS-1:0]      r_valid;
    logic [LEN_W+CODE_W-1:0] r_rd_word;
    logic                    r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_len, i_wr_bits};
        end
        if (i_rd_en) begin
            r_rd_word <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    // an entry never loaded reads as an empty code
    assign o_rd_len  = r_rd_valid ? r_rd_word[LEN_W+CODE_W-1:CODE_W] : '0;
    assign o_rd_bits = r_rd_word[CODE_W-1:0];

endmodule

/* design/huffman_table_encoder_bit_packer.sv */
// top level: prefix-code table, bit packer and byte output buffer
//
// channel  | direction | tdata                                   | tuser | tlast
// ---------+-----------+-----------------------------------------+-------+---------
// s_axis   | in        | symbol[7:0] code_length[13:8]           | mode  | -
//          |           | code_bits[45:14], zero pad [47:46]      | [1:0] |
// m_axis   | out       | out_byte[7:0]                           | -     | last
//
// an input transaction enters the table read stage; once the output buffer is empty
// or giving its final byte, the packer merges the code into the bit accumulator and
// hands 0 to 5 bytes to the output buffer. one input transaction per cycle while each
// item yields at most one byte; a longer item holds the packer until the buffer gives
// its final byte, one per output transaction. a stalled output backs up into o_s_axis_tready.
// reset clears the accumulator, the buffer and every table valid bit at once,
// so no clearing pass is needed; o_s_axis_tready stays low while reset is held.
module huffman_table_encoder_bit_packer
    import hte_pkg::*;
#(
    parameter int SYMBOLS      = SYMBOLS_DEF,
    parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [IN_W-1:0]   i_s_axis_tdata,   // symbol, code_length, code_bits
    input  logic [MODE_W-1:0] i_s_axis_tuser,   // mode
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [BYTE_W-1:0] o_m_axis_tdata,   // out_byte
    output logic              o_m_axis_tlast
);

    localparam int IDX_W     = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
    localparam int CLAMP_LEN = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
    localparam bit HAS_EOT   = (SYMBOLS > EOT_SYMBOL);

    // ---------------------------------------------------------------
    // input transaction fields
    // ---------------------------------------------------------------
    logic              s_accept;
    logic              m_accept;
    t_mode             in_mode;
    logic [SYM_W-1:0]  in_symbol;
    logic [LEN_W-1:0]  in_len;
    logic [CODE_W-1:0] in_bits;
    logic [LEN_W-1:0]  in_len_clamped;
    logic              in_range;

    assign in_mode   = t_mode'(i_s_axis_tuser);
    assign in_symbol = i_s_axis_tdata[SYM_W-1:0];
    assign in_len    = i_s_axis_tdata[SYM_W+LEN_W-1:SYM_W];
    assign in_bits   = i_s_axis_tdata[SYM_W+LEN_W+CODE_W-1:SYM_W+LEN_W];

    assign in_range       = ({1'b0, in_symbol} < (SYM_W+1)'(SYMBOLS));
    assign in_len_clamped = (in_len > LEN_W'(CLAMP_LEN)) ? LEN_W'(CLAMP_LEN) : in_len;

    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign m_accept = o_m_axis_tvalid && i_m_axis_tready;

    // ---------------------------------------------------------------
    // code table: loads write at acceptance, encode and end items read there
    // ---------------------------------------------------------------
    logic              tbl_wr_en;
    logic [IDX_W-1:0]  tbl_rd_addr;
    logic [LEN_W-1:0]  tbl_rd_len;
    logic [CODE_W-1:0] tbl_rd_bits;

    assign tbl_wr_en   = s_accept && (in_mode == MODE_LOAD) && in_range;
    assign tbl_rd_addr = (in_mode == MODE_END) ? IDX_W'(EOT_SYMBOL)
                                               : in_symbol[IDX_W-1:0];

    hte_table #(
        .SYMBOLS (SYMBOLS)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (tbl_wr_en),
        .i_wr_addr (in_symbol[IDX_W-1:0]),
        .i_wr_len  (in_len_clamped),
        .i_wr_bits (in_bits),
        .i_rd_en   (s_accept),
        .i_rd_addr (tbl_rd_addr),
        .o_rd_len  (tbl_rd_len),
        .o_rd_bits (tbl_rd_bits)
    );

    // ---------------------------------------------------------------
    // packer stage registers
    // ---------------------------------------------------------------
    logic        r_s1_valid;
    logic [MODE_W-1:0] r_s1_mode;
    logic        r_s1_hit;      // symbol addresses a table entry

    logic [BYTE_W-1:0] r_acc;   // held bits, first bit in the msb
    logic [PEND_W-1:0] r_pend;  // number of held bits, 0..8
    logic              r_bcb;   // only held bit is a 0 that followed a full byte

    logic [STREAM_W-1:0] r_ob_data;  // pending output bytes, next one on top
    logic [CNT_W-1:0]    r_ob_cnt;
    logic                r_ob_last;

    logic s1_go;

    // the packer hands over when the buffer is empty or giving its final byte now
    assign s1_go = r_s1_valid
                && ((r_ob_cnt == '0) || ((r_ob_cnt == CNT_W'(1)) && m_accept));
    assign o_s_axis_tready = i_rst_n && (!r_s1_valid || s1_go);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_mode <= i_s_axis_tuser;
            r_s1_hit  <= (in_mode == MODE_END) ? HAS_EOT : in_range;
        end
    end

    // ---------------------------------------------------------------
    // bit packing: held bits followed by the code, cut into bytes
    // ---------------------------------------------------------------
    logic [LEN_W-1:0]    code_len;
    logic [CODE_W-1:0]   code_left;
    logic [STREAM_W-1:0] stream;
    logic [STREAM_W-1:0] stream_tail;
    logic [LEN_W-1:0]    n_total;
    logic [LEN_W-1:0]    n_total_m1;
    logic [LEN_W-1:0]    n_rem_full;
    logic [CNT_W-1:0]    n_emit;
    logic [BYTE_W-1:0]   n_acc;
    logic [PEND_W-1:0]   n_pend;
    logic                n_bcb;
    logic [CNT_W-1:0]    n_ob_cnt;
    logic                n_ob_last;
    logic [BYTE_W-1:0]   n_acc_q;
    logic [PEND_W-1:0]   n_pend_q;
    logic                n_bcb_q;

    always_comb begin
        code_len    = r_s1_hit ? tbl_rd_len : '0;
        // left-align the code; an empty code shifts out entirely
        code_left   = tbl_rd_bits << (LEN_W'(CODE_W) - code_len);
        stream      = {r_acc, {CODE_W{1'b0}}} | ({code_left, {BYTE_W{1'b0}}} >> r_pend);
        n_total     = LEN_W'(r_pend) + code_len;
        n_total_m1  = n_total - LEN_W'(1);
        // bytes completed and followed by another bit: keep the last 1..8 bits
        n_emit      = (n_total == '0) ? '0 : CNT_W'(n_total_m1 >> 3);
        n_rem_full  = n_total - {n_emit, 3'b000};
        n_pend      = n_rem_full[PEND_W-1:0];
        stream_tail = stream << {n_emit, 3'b000};
        n_acc       = stream_tail[STREAM_W-1:STREAM_W-BYTE_W];
        n_bcb       = (code_len != '0)
                    ? ((n_pend == PEND_W'(1)) && (n_total > LEN_W'(BYTE_W)) && !n_acc[BYTE_W-1])
                    : r_bcb;

        n_ob_cnt  = '0;
        n_ob_last = 1'b0;
        n_acc_q   = r_acc;
        n_pend_q  = r_pend;
        n_bcb_q   = r_bcb;
        case (r_s1_mode)
            MODE_ENCODE: begin
                n_ob_cnt = n_emit;
                n_acc_q  = n_acc;
                n_pend_q = n_pend;
                n_bcb_q  = n_bcb;
            end
            MODE_END: begin
                // the partial byte sits right after the full ones in the stream;
                // a lone 0 after a full byte is dropped
                n_ob_cnt  = n_bcb ? n_emit : n_emit + CNT_W'(1);
                n_ob_last = 1'b1;
                n_acc_q   = '0;
                n_pend_q  = '0;
                n_bcb_q   = 1'b0;
            end
            default: begin
                n_ob_cnt = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_pend <= '0;
            r_bcb  <= 1'b0;
        end else if (s1_go) begin
            r_acc  <= n_acc_q;
            r_pend <= n_pend_q;
            r_bcb  <= n_bcb_q;
        end
    end

    // ---------------------------------------------------------------
    // output buffer: up to five bytes, shifted out msb byte first
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_cnt  <= '0;
            r_ob_last <= 1'b0;
        end else if (s1_go) begin
            r_ob_cnt  <= n_ob_cnt;
            r_ob_last <= n_ob_last;
        end else if (m_accept) begin
            r_ob_cnt  <= r_ob_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_ob_data <= stream;
        end else if (m_accept) begin
            r_ob_data <= r_ob_data << BYTE_W;
        end
    end

    assign o_m_axis_tvalid = (r_ob_cnt != '0);
    assign o_m_axis_tdata  = r_ob_data[STREAM_W-1:STREAM_W-BYTE_W];
    assign o_m_axis_tlast  = r_ob_last && (r_ob_cnt == CNT_W'(1));

endmodule

/* tb/testbench.sv */
// self-checking testbench of the prefix-code table encoder and bit packer
module testbench
    import hte_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // tuser carries the mode; code 3 is not an enum member but must be sent
    localparam bit [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_ITEMS  = 400;
    localparam int QUIET_ITEMS   = 60;    // tail of the run with no idling
    localparam int PAUSE_AT      = 200;   // sender holds off here until all bytes are out
    localparam int DRAIN_CYCLES  = 20;
    localparam int PRINT_CAP     = 40;

    // one output byte as it should leave the packer
    typedef struct packed {
        bit [BYTE_W-1:0] value;
        bit              is_last;
    } t_packed_byte;

    // one row of the directed stimulus; typed rows carry their expected output
    typedef struct {
        bit [MODE_W-1:0] mode;
        bit [SYM_W-1:0]  sym;
        bit [LEN_W-1:0]  len;
        bit [CODE_W-1:0] code;
        bit              typed;
        int              n_out;
        bit [BYTE_W-1:0] out_value;
        bit              out_last;
    } t_stim_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_axis_tvalid;
    logic              o_s_axis_tready;
    logic [IN_W-1:0]   i_s_axis_tdata;    // symbol[7:0], code_length[13:8], code_bits[45:14]
    logic [MODE_W-1:0] i_s_axis_tuser;    // mode[1:0]
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready;
    logic [BYTE_W-1:0] o_m_axis_tdata;    // out_byte[7:0]
    logic              o_m_axis_tlast;

    huffman_table_encoder_bit_packer u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // ------------------------------------------------------------------
    // shadow copy of the encoder state
    // ------------------------------------------------------------------
    bit [CODE_W-1:0] shadow_code [SYMBOLS_DEF];
    bit [LEN_W-1:0]  shadow_len  [SYMBOLS_DEF];
    bit [BYTE_W-1:0] shadow_acc;
    int unsigned     shadow_held;         // bits sitting in the accumulator, 0..8
    bit              shadow_lone_zero;    // only held bit is a 0 right after a full byte

    t_packed_byte fresh_bytes[$];         // bytes produced by the transaction just accepted
    t_packed_byte bytes_due[$];           // bytes still to come out of the block, oldest first

    bit quiet;                            // no idling on either side once set
    int errors;
    int n_load, n_encode, n_end, n_unused;
    int bytes_seen, lasts_seen;

    // directed part: extremes of every field, every mode and the corner cases
    t_stim_row directed_rows [0:DIRECTED_ROWS-1] = '{
        // flush with nothing held right after reset: one zero byte marked last
        '{MODE_END,    8'd0,   6'd0,  32'h0000_0000, 1'b1, 1, 8'h00, 1'b1},
        // unused mode with every field at its top: ignored
        '{MODE_UNUSED, 8'hFF,  6'd63, 32'hFFFF_FFFF, 1'b1, 0, 8'h00, 1'b0},
        // empty code and out-of-range symbol: nothing added
        '{MODE_ENCODE, 8'd0,   6'd0,  32'h0000_0000, 1'b1, 0, 8'h00, 1'b0},
        '{MODE_ENCODE, 8'd200, 6'd0,  32'h0000_0000, 1'b1, 0, 8'h00, 1'b0},
        // load beyond the table: ignored; then a full-length code of ones for symbol 0
        '{MODE_LOAD,   8'd200, 6'd5,  32'h0000_001F, 1'b1, 0, 8'h00, 1'b0},
        '{MODE_LOAD,   8'd0,   6'd32, 32'hFFFF_FFFF, 1'b1, 0, 8'h00, 1'b0},
        // length above 32 is clamped
        '{MODE_LOAD,   8'd1,   6'd63, 32'hA5A5_A5A5, 1'b1, 0, 8'h00, 1'b0},
        '{MODE_LOAD,   8'd127, 6'd1,  32'h0000_0001, 1'b1, 0, 8'h00, 1'b0},
        '{MODE_LOAD,   8'd4,   6'd3,  32'h0000_0005, 1'b1, 0, 8'h00, 1'b0},
        // longest code of ones, then a one-bit code that pushes the full byte out
        '{MODE_ENCODE, 8'd0,   6'd0,  32'h0000_0000, 1'b0, 0, 8'h00, 1'b0},
        '{MODE_ENCODE, 8'd127, 6'd0,  32'h0000_0000, 1'b0, 0, 8'h00, 1'b0},
        // end with junk in the unused fields
        '{MODE_END,    8'hAA,  6'h2A, 32'h1234_5678, 1'b0, 0, 8'h00, 1'b0},
        '{MODE_LOAD,   8'd2,   6'd1,  32'h0000_0000, 1'b1, 0, 8'h00, 1'b0},
        '{MODE_LOAD,   8'd3,   6'd8,  32'h0000_005A, 1'b1, 0, 8'h00, 1'b0},
        '{MODE_ENCODE, 8'd3,   6'd0,  32'h0000_0000, 1'b0, 0, 8'h00, 1'b0},
        '{MODE_ENCODE, 8'd2,   6'd0,  32'h0000_0000, 1'b0, 0, 8'h00, 1'b0},
        // no end-of-text code: the lone zero is dropped and nothing carries last
        '{MODE_LOAD,   8'd4,   6'd0,  32'h0000_0000, 1'b1, 0, 8'h00, 1'b0},
        '{MODE_END,    8'd0,   6'd0,  32'h0000_0000, 1'b0, 0, 8'h00, 1'b0},
        // end-of-text code ending in a lone zero: last moves to the full byte
        '{MODE_LOAD,   8'd4,   6'd9,  32'h0000_01FE, 1'b1, 0, 8'h00, 1'b0},
        '{MODE_END,    8'd0,   6'd0,  32'h0000_0000, 1'b0, 0, 8'h00, 1'b0},
        '{MODE_ENCODE, 8'd1,   6'd0,  32'h0000_0000, 1'b0, 0, 8'h00, 1'b0},
        '{MODE_END,    8'd0,   6'd0,  32'h0000_0000, 1'b0, 0, 8'h00, 1'b0},
        // longest end-of-text code of zeros: the end item yields five bytes
        '{MODE_LOAD,   8'd4,   6'd32, 32'h0000_0000, 1'b1, 0, 8'h00, 1'b0},
        '{MODE_ENCODE, 8'd0,   6'd0,  32'h0000_0000, 1'b0, 0, 8'h00, 1'b0},
        '{MODE_END,    8'd0,   6'd0,  32'h0000_0000, 1'b0, 0, 8'h00, 1'b0}
    };

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    // append one code bit; a full byte leaves only when the next bit arrives
    task automatic shift_in_bit(input bit b);
        if (shadow_held >= 8) begin
            fresh_bytes.push_back('{value: shadow_acc, is_last: 1'b0});
            shadow_acc       = '0;
            shadow_held      = 0;
            shadow_lone_zero = (b == 1'b0);
        end else begin
            shadow_lone_zero = 1'b0;
        end
        if (b)
            shadow_acc = shadow_acc | (8'h80 >> shadow_held);
        shadow_held++;
    endtask

    // append the code of one symbol, first bit at position length - 1
    task automatic shift_in_code(input int unsigned s);
        int unsigned n;
        if (s >= SYMBOLS_DEF)
            return;
        n = 32'(shadow_len[s]);
        if (n > CODE_W)
            n = CODE_W;
        for (int i = n; i > 0; i--)
            shift_in_bit(shadow_code[s][i-1]);
    endtask

    // work out the bytes caused by one accepted input transaction
    task automatic pack_transaction(input bit [MODE_W-1:0] mode, input bit [SYM_W-1:0] sym,
                                    input bit [LEN_W-1:0] len, input bit [CODE_W-1:0] code);
        int unsigned n;
        fresh_bytes.delete();
        case (mode)
            MODE_LOAD: begin
                if (sym < SYMBOLS_DEF) begin
                    n = 32'(len);
                    if (n > CODE_W)
                        n = CODE_W;
                    if (n > MAX_CODE_LEN_DEF)
                        n = MAX_CODE_LEN_DEF;
                    shadow_len[sym]  = n[LEN_W-1:0];
                    shadow_code[sym] = code;
                end
            end
            MODE_ENCODE: begin
                shift_in_code(32'(sym));
            end
            MODE_END: begin
                shift_in_code(EOT_SYMBOL);
                if (!shadow_lone_zero)
                    fresh_bytes.push_back('{value: shadow_acc, is_last: 1'b1});
                else if (fresh_bytes.size() > 0)
                    fresh_bytes[fresh_bytes.size()-1].is_last = 1'b1;
                shadow_acc       = '0;
                shadow_held      = 0;
                shadow_lone_zero = 1'b0;
            end
            default: begin
                // unused mode leaves everything untouched
            end
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        if (errors < PRINT_CAP)
            $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // input side: one transaction per call, gaps drawn at random
    // ------------------------------------------------------------------
    task automatic send_item(input bit [MODE_W-1:0] mode, input bit [SYM_W-1:0] sym,
                             input bit [LEN_W-1:0] len, input bit [CODE_W-1:0] code,
                             input bit typed, input int n_out,
                             input bit [BYTE_W-1:0] out_value, input bit out_last);
        // entered and left at a falling edge
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_s_axis_tdata  = {2'b00, code, len, sym};
        i_s_axis_tuser  = mode;
        i_s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        // transaction taken at this edge: record what it must produce
        pack_transaction(mode, sym, len, code);
        if (typed) begin
            for (int k = 0; k < n_out; k++)
                bytes_due.push_back('{value: out_value, is_last: out_last});
        end else begin
            foreach (fresh_bytes[k])
                bytes_due.push_back(fresh_bytes[k]);
        end
        case (mode)
            MODE_LOAD:   n_load++;
            MODE_ENCODE: n_encode++;
            MODE_END:    n_end++;
            default:     n_unused++;
        endcase
        @(negedge i_clk);
    endtask

    // pick a symbol whose code is not empty, most of the time
    function automatic bit [SYM_W-1:0] pick_coded_symbol();
        bit [SYM_W-1:0] s;
        s = SYM_W'($urandom_range(0, SYMBOLS_DEF - 1));
        for (int t = 0; t < 16; t++) begin
            if (shadow_len[s] != 0)
                return s;
            s = SYM_W'($urandom_range(0, SYMBOLS_DEF - 1));
        end
        return s;
    endfunction

    // random transaction: mostly encodes of loaded symbols, some loads and ends,
    // a sprinkling of unused modes and out-of-range symbols
    task automatic send_random_item();
        bit [MODE_W-1:0] mode;
        bit [SYM_W-1:0]  sym;
        bit [LEN_W-1:0]  len;
        bit [CODE_W-1:0] code;
        int              pick;
        pick = $urandom_range(0, 99);
        len  = LEN_W'($urandom_range(0, 63));
        code = $urandom;
        if (pick < 20) begin
            mode = MODE_LOAD;
            pick = $urandom_range(0, 99);
            if (pick < 10)
                sym = SYM_W'($urandom_range(SYMBOLS_DEF, 255));
            else if (pick < 22)
                sym = SYM_W'(EOT_SYMBOL);
            else
                sym = SYM_W'($urandom_range(0, SYMBOLS_DEF - 1));
            pick = $urandom_range(0, 99);
            if (pick < 70)
                len = LEN_W'($urandom_range(1, 10));
            else if (pick < 80)
                len = '0;
            else if (pick < 90)
                len = LEN_W'($urandom_range(11, 32));
            else
                len = LEN_W'($urandom_range(33, 63));
        end else if (pick < 88) begin
            mode = MODE_ENCODE;
            pick = $urandom_range(0, 99);
            if (pick < 85)
                sym = pick_coded_symbol();
            else if (pick < 95)
                sym = SYM_W'($urandom_range(SYMBOLS_DEF, 255));
            else
                sym = SYM_W'($urandom_range(0, SYMBOLS_DEF - 1));
        end else if (pick < 96) begin
            mode = MODE_END;
            sym  = SYM_W'($urandom);
        end else begin
            mode = MODE_UNUSED;
            sym  = SYM_W'($urandom);
        end
        send_item(mode, sym, len, code, 1'b0, 0, 8'h00, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // output side: random stall bursts, always ready in the quiet tail
    // ------------------------------------------------------------------
    initial begin
        int run;
        i_m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (quiet || $urandom_range(0, 2) != 0) begin
                i_m_axis_tready = 1'b1;
                run = $urandom_range(1, 12);
            end else begin
                i_m_axis_tready = 1'b0;
                run = $urandom_range(1, 6);
            end
            repeat (run) @(negedge i_clk);
        end
    end

    // every output transaction is matched against the oldest byte due
    always @(posedge i_clk) begin
        t_packed_byte want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            bytes_seen++;
            if (o_m_axis_tlast)
                lasts_seen++;
            if (bytes_due.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %02h last %0b",
                                          o_m_axis_tdata, o_m_axis_tlast));
            end else begin
                want = bytes_due.pop_front();
                if (o_m_axis_tdata !== want.value)
                    report_mismatch($sformatf("byte %0d: got %02h want %02h",
                                              bytes_seen, o_m_axis_tdata, want.value));
                if (o_m_axis_tlast !== want.is_last)
                    report_mismatch($sformatf("byte %0d: last got %0b want %0b",
                                              bytes_seen, o_m_axis_tlast, want.is_last));
            end
        end
    end

    // watchdog, far above the slowest legal run
    initial begin
        #2_000_000;
        $display("[huffman_table_encoder_bit_packer] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        quiet           = 1'b0;
        errors          = 0;
        shadow_acc      = '0;
        shadow_held     = 0;
        shadow_lone_zero = 1'b0;
        foreach (shadow_len[s]) begin
            shadow_len[s]  = '0;
            shadow_code[s] = '0;
        end
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[r])
            send_item(directed_rows[r].mode, directed_rows[r].sym, directed_rows[r].len,
                      directed_rows[r].code, directed_rows[r].typed, directed_rows[r].n_out,
                      directed_rows[r].out_value, directed_rows[r].out_last);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == PAUSE_AT) begin
                // hold the input off until the packer has handed out every byte
                i_s_axis_tvalid = 1'b0;
                while (bytes_due.size() != 0)
                    @(posedge i_clk);
                @(negedge i_clk);
            end
            if (i == RANDOM_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            send_random_item();
        end
        // close the stream so the tail of the accumulator comes out too
        send_item(MODE_END, 8'd0, 6'd0, 32'd0, 1'b0, 0, 8'h00, 1'b0);
        i_s_axis_tvalid = 1'b0;

        while (bytes_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d loads, %0d encodes, %0d ends, %0d unused-mode items",
                 n_load, n_encode, n_end, n_unused);
        $display("checked %0d output bytes, %0d of them closing a stream, %0d mismatches",
                 bytes_seen, lasts_seen, errors);
        if (errors == 0)
            $display("[huffman_table_encoder_bit_packer] OK");
        else
            $display("[huffman_table_encoder_bit_packer] ERROR");
        $finish;
    end

endmodule
